### rtl/lkvc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the LRU key-value cache.
// Used by the controller, the datapath and the top level.
package lkvc_pkg;

  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;
  localparam int ADDR_W = 3;

  // Register map (byte addresses).
  localparam logic [ADDR_W-1:0] ADDR_CAPACITY = 3'd0;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic [DATA_W-1:0] MISS_VALUE = {DATA_W{1'b1}};

  // Operation codes carried in the input tuser.
  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_SET = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic scan_start;
    logic apply;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic is_get;
    logic hit;
    logic out_free;
  } status_t;

endpackage

### rtl/lkvc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lkvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/lkvc_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the LRU key-value cache.
// Depends on lkvc_pkg for the command and status structs.
module lkvc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  lkvc_pkg::status_t status,
  output lkvc_pkg::cmd_t    cmd
);
  import lkvc_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_APPLY  = 3'd2;
  localparam logic [2:0] ST_RDWAIT = 3'd3;
  localparam logic [2:0] ST_RESP   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in    = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        if (!status.is_get) begin
          state_next = ST_IDLE;
        end else if (status.hit) begin
          state_next = ST_RDWAIT;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_RDWAIT: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/lkvc_datapath.sv
`timescale 1ns / 1ps
// Datapath of the LRU key-value cache: key and value RAMs, valid bits,
// age ranks, the key scan and the output register. Depends on lkvc_pkg
// and lkvc_ram.
module lkvc_datapath #(
  parameter int ENTRIES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lkvc_pkg::cmd_t              cmd,
  output lkvc_pkg::status_t           status,
  input  logic [lkvc_pkg::CAP_W-1:0]  capacity,
  input  logic                        in_kind,
  input  logic [lkvc_pkg::DATA_W-1:0] in_key,
  input  logic [lkvc_pkg::DATA_W-1:0] in_value,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic                        out_hit,
  output logic [lkvc_pkg::DATA_W-1:0] out_value
);
  import lkvc_pkg::*;

  localparam int IW   = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int CMPW = CW > CAP_W ? CW : CAP_W;

  // Latched request.
  logic              kind_q;
  logic [DATA_W-1:0] key_q;
  logic [DATA_W-1:0] value_q;

  // Scan control.
  logic [IW:0]   scan_cnt;
  logic          scan_run;
  logic          chk;
  logic [IW-1:0] chk_idx;

  // Scan results.
  logic          m_found;
  logic [IW-1:0] m_slot;
  logic          f_found;
  logic [IW-1:0] f_slot;
  logic [IW-1:0] o_slot;
  logic [IW-1:0] s_slot;

  // Replacement state.
  logic [ENTRIES-1:0] valid;
  logic [IW-1:0]      rank [ENTRIES];
  logic [CW-1:0]      count;

  logic [DATA_W-1:0] key_rdata;
  logic [DATA_W-1:0] val_rdata;

  logic          full;
  logic          insert;
  logic [IW-1:0] ins_slot;
  logic [CW-1:0] new_count;
  logic          evict;
  logic [IW-1:0] target;
  logic [IW-1:0] touch_rank;
  logic [CW-1:0] chk_rank;
  logic          chk_valid;

  // Insert and eviction decisions, all from the ranks seen before the update.
  assign full       = (count == CW'(ENTRIES));
  assign insert     = cmd.apply && (kind_q == KIND_SET) && !m_found;
  assign ins_slot   = full ? o_slot : f_slot;
  assign new_count  = full ? count : count + CW'(1);
  assign evict      = CMPW'(new_count) > CMPW'(capacity);
  assign touch_rank = rank[m_slot];
  assign chk_valid  = valid[chk_idx];
  assign chk_rank   = CW'(rank[chk_idx]);

  always_comb begin
    if (full) begin
      target = (ENTRIES == 1) ? ins_slot : s_slot;
    end else if (count == '0) begin
      target = ins_slot;
    end else begin
      target = o_slot;
    end
  end

  // Request register.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_q  <= in_kind;
      key_q   <= in_key;
      value_q <= in_value;
    end
  end

  // Scan sequencer: one key RAM read per cycle, each checked in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_run <= 1'b0;
      chk      <= 1'b0;
    end else begin
      chk <= scan_run;
      if (cmd.scan_start) begin
        scan_run <= 1'b1;
      end else if (scan_run && scan_cnt == (IW + 1)'(ENTRIES - 1)) begin
        scan_run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_cnt <= '0;
    end else if (scan_run) begin
      scan_cnt <= scan_cnt + (IW + 1)'(1);
    end
    chk_idx <= scan_cnt[IW-1:0];
  end

  assign status.scan_done = chk && (chk_idx == IW'(ENTRIES - 1));

  // Collect match, first free slot, oldest and second oldest entries.
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      m_found <= 1'b0;
      f_found <= 1'b0;
    end else if (chk) begin
      if (chk_valid && key_rdata == key_q) begin
        m_found <= 1'b1;
        m_slot  <= chk_idx;
      end
      if (!chk_valid && !f_found) begin
        f_found <= 1'b1;
        f_slot  <= chk_idx;
      end
      if (chk_valid && chk_rank == count - CW'(1)) begin
        o_slot <= chk_idx;
      end
      if (chk_valid && chk_rank == count - CW'(2)) begin
        s_slot <= chk_idx;
      end
    end
  end

  // Valid bits and age ranks, updated for all entries in parallel.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (cmd.apply) begin
      if (m_found) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (IW'(i) == m_slot) begin
            rank[i] <= '0;
          end else if (valid[i] && rank[i] < touch_rank) begin
            rank[i] <= rank[i] + IW'(1);
          end
        end
      end else if (insert) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (IW'(i) == ins_slot) begin
            valid[i] <= 1'b1;
            rank[i]  <= '0;
          end else if (valid[i]) begin
            rank[i] <= rank[i] + IW'(1);
          end
          if (evict && IW'(i) == target) begin
            valid[i] <= 1'b0;
            rank[i]  <= '0;
          end
        end
        count <= evict ? new_count - CW'(1) : new_count;
      end
    end
  end

  // Key store, read sequentially by the scan.
  lkvc_ram #(
    .WIDTH(DATA_W),
    .DEPTH(ENTRIES)
  ) u_key_ram (
    .clk  (clk),
    .we   (insert),
    .waddr(ins_slot),
    .wdata(key_q),
    .re   (scan_run),
    .raddr(scan_cnt[IW-1:0]),
    .rdata(key_rdata)
  );

  // Value store, written on every set and read on a get hit.
  lkvc_ram #(
    .WIDTH(DATA_W),
    .DEPTH(ENTRIES)
  ) u_value_ram (
    .clk  (clk),
    .we   (cmd.apply && kind_q == KIND_SET),
    .waddr(m_found ? m_slot : ins_slot),
    .wdata(value_q),
    .re   (cmd.apply && kind_q == KIND_GET && m_found),
    .raddr(m_slot),
    .rdata(val_rdata)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_hit   <= m_found;
      out_value <= m_found ? val_rdata : MISS_VALUE;
    end
  end

  assign status.is_get   = (kind_q == KIND_GET);
  assign status.hit      = m_found;
  assign status.out_free = !out_valid || out_ready;

endmodule

### rtl/lru_key_value_cache_unit.sv
`timescale 1ns / 1ps
// Top level of the LRU key-value cache: configuration port, controller
// and datapath. Depends on lkvc_pkg, lkvc_ctrl and lkvc_datapath.
//
// Usage:
//   The input stream carries one request per transfer: tuser is the kind
//   (0 get, 1 set), tdata holds the key in bits 31:0 and the value in
//   bits 63:32. Each get produces one response on the output stream: tuser
//   is the hit flag, tdata the stored value on a hit or all ones on a miss.
//   A set produces no response.
//   Timing: every request scans the key RAM one entry per cycle. From
//   acceptance to the next s_tready a request passes the scan, the apply
//   step, on a get hit the value RAM read wait, and on a get the response
//   step. One request is in work at a time.
//   The response waits in an output register; the block accepts the next
//   request while it waits. If the receiver still stalls when the next
//   response is ready, the block holds in its response state until the
//   register is free.
//   Reset empties the cache at once (no clearing pass) and sets capacity
//   to 16. Write capacity (APB address 0) only while idle; not enforced.
module lru_key_value_cache_unit #(
  parameter int ENTRIES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  // APB configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lkvc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // Request stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [63:0]                 s_tdata,  // key [31:0], value [63:32]
  input  logic                        s_tuser,  // kind [0]
  // Response stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [31:0]                 m_tdata,  // read_value [31:0]
  output logic                        m_tuser   // hit [0]
);
  import lkvc_pkg::*;

  logic [CAP_W-1:0] capacity;
  cmd_t             cmd;
  status_t          status;

  // Capacity register, written in the APB access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_CAPACITY) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  assign pready = 1'b1;

  // Register read decode.
  always_comb begin
    unique case (paddr)
      ADDR_CAPACITY: prdata = {{(32 - CAP_W){1'b0}}, capacity};
      default:       prdata = '0;
    endcase
  end

  lkvc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  lkvc_datapath #(
    .ENTRIES(ENTRIES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .capacity (capacity),
    .in_kind  (s_tuser),
    .in_key   (s_tdata[31:0]),
    .in_value (s_tdata[63:32]),
    .out_ready(m_tready),
    .out_valid(m_tvalid),
    .out_hit  (m_tuser),
    .out_value(m_tdata)
  );

endmodule
